@@ sv/assert_macros.svh @@
// assertion macros for the light bar pair feature block
// empty when SYNTHESIS is defined; used by the top level only
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/lpgf_pkg.sv @@
// shared types, widths and constants for the light bar pair feature block
// no dependencies
package lpgf_pkg;

  localparam int CORDIC_STAGES_DEF = 14;
  localparam int COORD_W = 16;
  localparam int AXIS_W = 18;
  localparam int ANGLE_W = 16;
  localparam int CORDIC_W = 34;
  localparam int Z_W = 18;
  localparam int PRESCALE_SH = 12;
  localparam int PI_Q13 = 25736;
  localparam int HALF_PI_Q13 = 12868;

  localparam int TILT_W = 15;
  localparam int RES_W = 16;
  localparam int SQ_W = 32;
  localparam int CSQ_W = 34;
  localparam int LEN2_W = 33;
  localparam int DIST2_W = 35;
  localparam int WR_SCALE_SH = 14;
  localparam int SR_SCALE_SH = 16;

  localparam int RATIO_DEN_W = LEN2_W;
  localparam int RATIO_Q_W = 32;
  localparam int ANG_DEN_W = TILT_W;
  localparam int ANG_Q_W = 16;
  localparam int ANG_SH = 8;

  localparam int PRE_STAGES = 4;
  localparam int PIPE_LAT = PRE_STAGES + RATIO_Q_W + RATIO_Q_W / 2;

  localparam logic [RES_W-1:0] SAT16 = '1;

  typedef struct packed {
    logic [COORD_W-1:0] left_top_x;
    logic [COORD_W-1:0] left_top_y;
    logic [COORD_W-1:0] left_bottom_x;
    logic [COORD_W-1:0] left_bottom_y;
    logic [COORD_W-1:0] right_top_x;
    logic [COORD_W-1:0] right_top_y;
    logic [COORD_W-1:0] right_bottom_x;
    logic [COORD_W-1:0] right_bottom_y;
  } in_word_t;

  typedef struct packed {
    logic [TILT_W-1:0] top_tilt;
    logic [TILT_W-1:0] bottom_tilt;
    logic [TILT_W-1:0] tilt_difference;
    logic [RES_W-1:0]  angle_quotient;
    logic [RES_W-1:0]  width_ratio;
    logic [RES_W-1:0]  length_ratio;
    logic [RES_W-1:0]  rect_error;
    logic [RES_W-1:0]  rect_error_diff;
    logic              divide_saturated;
  } out_word_t;

  function automatic logic [12:0] atan_q13(input int idx);
    case (idx)
      0:       return 13'd6434;
      1:       return 13'd3798;
      2:       return 13'd2007;
      3:       return 13'd1019;
      4:       return 13'd511;
      5:       return 13'd256;
      6:       return 13'd128;
      7:       return 13'd64;
      8:       return 13'd32;
      9:       return 13'd16;
      10:      return 13'd8;
      11:      return 13'd4;
      12:      return 13'd2;
      13:      return 13'd1;
      default: return 13'd0;
    endcase
  endfunction

endpackage

@@ sv/lpgf_delay.sv @@
// shift line that keeps side data aligned with the long arithmetic paths
// depends on nothing
module lpgf_delay #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

@@ sv/lpgf_cordic.sv @@
// pipelined vectoring cordic: atan2 in radians times 8192, one stage per iteration
// depends on lpgf_pkg
module lpgf_cordic #(
  parameter int STAGES = lpgf_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [lpgf_pkg::AXIS_W-1:0]  y_in,
  input  logic signed [lpgf_pkg::AXIS_W-1:0]  x_in,
  output logic signed [lpgf_pkg::ANGLE_W-1:0] angle
);
  import lpgf_pkg::*;

  localparam logic signed [Z_W-1:0] Z_PI = Z_W'(PI_Q13);
  localparam logic signed [Z_W-1:0] Z_NPI = Z_W'(-PI_Q13);
  localparam logic signed [Z_W-1:0] Z_HPI = Z_W'(HALF_PI_Q13);
  localparam logic signed [Z_W-1:0] Z_NHPI = Z_W'(-HALF_PI_Q13);

  logic signed [CORDIC_W-1:0] cx_r [0:STAGES];
  logic signed [CORDIC_W-1:0] cy_r [0:STAGES];
  logic signed [Z_W-1:0]      z_r  [0:STAGES];
  logic                       fix_r [0:STAGES];

  logic signed [CORDIC_W-1:0] px, py, cx0, cy0;
  logic signed [Z_W-1:0]      z0, zl, zc;
  logic                       fix0;

  assign px = {{(CORDIC_W-AXIS_W-PRESCALE_SH){x_in[AXIS_W-1]}}, x_in, {PRESCALE_SH{1'b0}}};
  assign py = {{(CORDIC_W-AXIS_W-PRESCALE_SH){y_in[AXIS_W-1]}}, y_in, {PRESCALE_SH{1'b0}}};

  // axis cases are exact and bypass the iterations
  always_comb begin
    fix0 = 1'b0;
    z0   = '0;
    cx0  = px;
    cy0  = py;
    if (y_in == '0) begin
      fix0 = 1'b1;
      z0   = x_in[AXIS_W-1] ? Z_PI : '0;
    end else if (x_in == '0) begin
      fix0 = 1'b1;
      z0   = y_in[AXIS_W-1] ? Z_NHPI : Z_HPI;
    end else if (x_in[AXIS_W-1]) begin
      z0  = y_in[AXIS_W-1] ? Z_NPI : Z_PI;
      cx0 = -px;
      cy0 = -py;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]  <= cx0;
      cy_r[0]  <= cy0;
      z_r[0]   <= z0;
      fix_r[0] <= fix0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    logic signed [Z_W-1:0] step;
    logic                  up;
    assign step = Z_W'({1'b0, atan_q13(i)});
    assign up = (cy_r[i] > 0);
    always_ff @(posedge clk) begin
      if (en) begin
        fix_r[i+1] <= fix_r[i];
        if (up) begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
        end else begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
        end
        if (fix_r[i]) begin
          z_r[i+1] <= z_r[i];
        end else if (up) begin
          z_r[i+1] <= z_r[i] + step;
        end else begin
          z_r[i+1] <= z_r[i] - step;
        end
      end
    end
  end

  assign zl = z_r[STAGES];

  always_comb begin
    if (zl > Z_PI) begin
      zc = Z_PI;
    end else if (zl < Z_NPI) begin
      zc = Z_NPI;
    end else begin
      zc = zl;
    end
  end

  assign angle = ANGLE_W'(zc);

endmodule

@@ sv/lpgf_divider.sv @@
// pipelined restoring divider, one quotient bit per stage
// caller guarantees num_hi < den; depends on nothing
module lpgf_divider #(
  parameter int DEN_W = 33,
  parameter int Q_W = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] num_hi,
  input  logic [Q_W-1:0]   num_lo,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quot
);

  logic [DEN_W-1:0] rem_r [0:Q_W-1];
  logic [DEN_W-1:0] den_r [0:Q_W-1];
  logic [Q_W-1:0]   lo_r  [0:Q_W-1];
  logic [Q_W-1:0]   q_r   [0:Q_W-1];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DEN_W-1:0] r_in, d_in;
    logic [Q_W-1:0]   l_in, q_in;
    logic [DEN_W:0]   trial, diff;
    logic             ge;
    if (k == 0) begin : g_first
      assign r_in = num_hi;
      assign d_in = den;
      assign l_in = num_lo;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_r[k-1];
      assign d_in = den_r[k-1];
      assign l_in = lo_r[k-1];
      assign q_in = q_r[k-1];
    end
    assign trial = {r_in, l_in[Q_W-1]};
    assign diff = trial - {1'b0, d_in};
    assign ge = (trial >= {1'b0, d_in});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_r[k] <= d_in;
        lo_r[k]  <= {l_in[Q_W-2:0], 1'b0};
        q_r[k]   <= {q_in[Q_W-2:0], ge};
      end
    end
  end

  assign quot = q_r[Q_W-1];

endmodule

@@ sv/lpgf_isqrt.sv @@
// pipelined integer square root, one root bit per stage
// depends on nothing
module lpgf_isqrt #(
  parameter int IN_W = 32
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   rad,
  output logic [IN_W/2-1:0] root
);

  localparam int HW = IN_W / 2;

  logic [HW:0]     rem_r  [0:HW-1];
  logic [HW-1:0]   root_r [0:HW-1];
  logic [IN_W-1:0] rad_r  [0:HW-1];

  for (genvar k = 0; k < HW; k++) begin : g_stage
    logic [HW:0]     r_in;
    logic [HW-1:0]   o_in;
    logic [IN_W-1:0] s_in;
    logic [HW+2:0]   t, trial, diff;
    logic            ge;
    if (k == 0) begin : g_first
      assign r_in = '0;
      assign o_in = '0;
      assign s_in = rad;
    end else begin : g_next
      assign r_in = rem_r[k-1];
      assign o_in = root_r[k-1];
      assign s_in = rad_r[k-1];
    end
    assign t = {r_in, s_in[IN_W-1:IN_W-2]};
    assign trial = {1'b0, o_in, 2'b01};
    assign diff = t - trial;
    assign ge = (t >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[HW:0] : t[HW:0];
        root_r[k] <= {o_in[HW-2:0], ge};
        rad_r[k]  <= {s_in[IN_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[HW-1];

endmodule

@@ sv/lightbar_pair_geometry_features.sv @@
// channel | handshake            | word
// in      | in_valid / in_ready  | in_word   (lpgf_pkg::in_word_t, two bar axes)
// out     | out_valid / out_ready| out_word  (lpgf_pkg::out_word_t, eight features, one flag)
// one word per cycle while the skid entry is empty; depth PIPE_LAT plus the output register, set by the ratio path:
// four setup stages, a 32-stage divider and a 16-stage square root
// the cordic and angle divider paths are shorter and delayed to match
// output register plus one skid entry; a stall freezes the whole pipeline
// synchronous active-low reset clears the valid bits only
// depends on lpgf_pkg, lpgf_cordic, lpgf_divider, lpgf_isqrt, lpgf_delay
`include "assert_macros.svh"
module lightbar_pair_geometry_features #(
  parameter int CORDIC_STAGES = lpgf_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpgf_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output lpgf_pkg::out_word_t out_word
);
  import lpgf_pkg::*;

  localparam int ANG_SIDE_DELAY = PIPE_LAT - (CORDIC_STAGES + 4);
  localparam int ANG_Q_DELAY = PIPE_LAT - (CORDIC_STAGES + 4 + ANG_Q_W);
  localparam int SAT_DELAY = PIPE_LAT - PRE_STAGES;

  typedef struct packed {
    logic              aq_sat;
    logic [TILT_W-1:0] top;
    logic [TILT_W-1:0] bot;
    logic [TILT_W-1:0] tdiff;
    logic [RES_W-1:0]  rerr;
    logic [RES_W-1:0]  rdiff;
  } ang_side_t;

  logic en;
  logic [PIPE_LAT:1] vld_r;
  logic out_valid_r, skid_full_r;
  out_word_t out_word_r, skid_word_r, fin;

  assign en = !skid_full_r;
  assign in_ready = en;

  // axis differences
  logic signed [AXIS_W-1:0] ldx_r, ldy_r, rdx_r, rdy_r, tdx_r, tdy_r, bdx_r, bdy_r;
  logic signed [AXIS_W-1:0] cdx_r, cdy_r;

  function automatic logic signed [AXIS_W-1:0] sub16(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
    return $signed(AXIS_W'(a)) - $signed(AXIS_W'(b));
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      ldx_r <= sub16(in_word.left_bottom_x, in_word.left_top_x);
      ldy_r <= sub16(in_word.left_bottom_y, in_word.left_top_y);
      rdx_r <= sub16(in_word.right_bottom_x, in_word.right_top_x);
      rdy_r <= sub16(in_word.right_bottom_y, in_word.right_top_y);
      tdx_r <= sub16(in_word.right_top_x, in_word.left_top_x);
      tdy_r <= sub16(in_word.right_top_y, in_word.left_top_y);
      bdx_r <= sub16(in_word.right_bottom_x, in_word.left_bottom_x);
      bdy_r <= sub16(in_word.right_bottom_y, in_word.left_bottom_y);
      cdx_r <= $signed(AXIS_W'(in_word.left_top_x) + AXIS_W'(in_word.left_bottom_x))
             - $signed(AXIS_W'(in_word.right_top_x) + AXIS_W'(in_word.right_bottom_x));
      cdy_r <= $signed(AXIS_W'(in_word.left_top_y) + AXIS_W'(in_word.left_bottom_y))
             - $signed(AXIS_W'(in_word.right_top_y) + AXIS_W'(in_word.right_bottom_y));
    end
  end

  // squares
  logic signed [2*AXIS_W-1:0] p_ldx, p_ldy, p_rdx, p_rdy, p_cdx, p_cdy;
  logic [SQ_W-1:0]  ldx2_r, ldy2_r, rdx2_r, rdy2_r;
  logic [CSQ_W-1:0] cdx2_r, cdy2_r;

  assign p_ldx = ldx_r * ldx_r;
  assign p_ldy = ldy_r * ldy_r;
  assign p_rdx = rdx_r * rdx_r;
  assign p_rdy = rdy_r * rdy_r;
  assign p_cdx = cdx_r * cdx_r;
  assign p_cdy = cdy_r * cdy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ldx2_r <= p_ldx[SQ_W-1:0];
      ldy2_r <= p_ldy[SQ_W-1:0];
      rdx2_r <= p_rdx[SQ_W-1:0];
      rdy2_r <= p_rdy[SQ_W-1:0];
      cdx2_r <= p_cdx[CSQ_W-1:0];
      cdy2_r <= p_cdy[CSQ_W-1:0];
    end
  end

  // squared lengths
  logic [LEN2_W-1:0]  l2_r, r2_r;
  logic [DIST2_W-1:0] d2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      l2_r <= LEN2_W'(ldx2_r) + LEN2_W'(ldy2_r);
      r2_r <= LEN2_W'(rdx2_r) + LEN2_W'(rdy2_r);
      d2_r <= DIST2_W'(cdx2_r) + DIST2_W'(cdy2_r);
    end
  end

  // divider operands and overflow checks
  logic [LEN2_W-1:0] lmax, lmin, wr_hi, sr_hi;
  logic wr_sat, sr_sat;
  logic [RATIO_DEN_W-1:0] wr_hi_r, wr_den_r, sr_hi_r, sr_den_r;
  logic [RATIO_Q_W-1:0]   wr_lo_r, sr_lo_r;
  logic wr_sat_r, sr_sat_r;

  assign lmax = (l2_r > r2_r) ? l2_r : r2_r;
  assign lmin = (l2_r > r2_r) ? r2_r : l2_r;
  assign wr_hi = LEN2_W'(d2_r >> (RATIO_Q_W - WR_SCALE_SH));
  assign sr_hi = lmax >> (RATIO_Q_W - SR_SCALE_SH);
  assign wr_sat = (wr_hi >= lmax);
  assign sr_sat = (sr_hi >= lmin);

  always_ff @(posedge clk) begin
    if (en) begin
      wr_hi_r  <= wr_sat ? '0 : wr_hi;
      wr_lo_r  <= {d2_r[RATIO_Q_W-WR_SCALE_SH-1:0], {WR_SCALE_SH{1'b0}}};
      wr_den_r <= lmax;
      wr_sat_r <= wr_sat;
      sr_hi_r  <= sr_sat ? '0 : sr_hi;
      sr_lo_r  <= {lmax[RATIO_Q_W-SR_SCALE_SH-1:0], {SR_SCALE_SH{1'b0}}};
      sr_den_r <= lmin;
      sr_sat_r <= sr_sat;
    end
  end

  logic [RATIO_Q_W-1:0]   wr_q, sr_q;
  logic [RATIO_Q_W/2-1:0] wr_root, sr_root;
  logic [1:0]             rsat_d;

  lpgf_divider #(.DEN_W(RATIO_DEN_W), .Q_W(RATIO_Q_W)) u_wr_div (
    .clk(clk), .en(en), .num_hi(wr_hi_r), .num_lo(wr_lo_r), .den(wr_den_r), .quot(wr_q)
  );
  lpgf_divider #(.DEN_W(RATIO_DEN_W), .Q_W(RATIO_Q_W)) u_sr_div (
    .clk(clk), .en(en), .num_hi(sr_hi_r), .num_lo(sr_lo_r), .den(sr_den_r), .quot(sr_q)
  );
  lpgf_isqrt #(.IN_W(RATIO_Q_W)) u_wr_sqrt (.clk(clk), .en(en), .rad(wr_q), .root(wr_root));
  lpgf_isqrt #(.IN_W(RATIO_Q_W)) u_sr_sqrt (.clk(clk), .en(en), .rad(sr_q), .root(sr_root));
  lpgf_delay #(.W(2), .DEPTH(SAT_DELAY)) u_rsat_dly (
    .clk(clk), .en(en), .d({wr_sat_r, sr_sat_r}), .q(rsat_d)
  );

  // angles
  logic signed [ANGLE_W-1:0] la, ra, ta, ba, roll;

  lpgf_cordic #(.STAGES(CORDIC_STAGES)) u_cor_l (
    .clk(clk), .en(en), .y_in(ldy_r), .x_in(ldx_r), .angle(la)
  );
  lpgf_cordic #(.STAGES(CORDIC_STAGES)) u_cor_r (
    .clk(clk), .en(en), .y_in(rdy_r), .x_in(rdx_r), .angle(ra)
  );
  lpgf_cordic #(.STAGES(CORDIC_STAGES)) u_cor_t (
    .clk(clk), .en(en), .y_in(tdy_r), .x_in(tdx_r), .angle(ta)
  );
  lpgf_cordic #(.STAGES(CORDIC_STAGES)) u_cor_b (
    .clk(clk), .en(en), .y_in(bdy_r), .x_in(bdx_r), .angle(ba)
  );
  lpgf_cordic #(.STAGES(CORDIC_STAGES)) u_cor_c (
    .clk(clk), .en(en), .y_in(cdy_r), .x_in(cdx_r), .angle(roll)
  );

  function automatic logic [TILT_W-1:0] abs_ang(input logic signed [ANGLE_W-1:0] a);
    logic signed [ANGLE_W-1:0] m;
    m = a[ANGLE_W-1] ? -a : a;
    return m[TILT_W-1:0];
  endfunction

  function automatic logic [RES_W-1:0] rect_err(input logic signed [ANGLE_W-1:0] a,
                                                input logic signed [ANGLE_W-1:0] r);
    logic signed [ANGLE_W+1:0] e;
    e = (ANGLE_W+2)'(a) - (ANGLE_W+2)'(r) - (ANGLE_W+2)'(HALF_PI_Q13);
    if (e[ANGLE_W+1]) begin
      e = -e;
    end
    return e[RES_W-1:0];
  endfunction

  logic [TILT_W-1:0] ta_abs_r, ba_abs_r, la_abs_r, ra_abs_r;
  logic [RES_W-1:0]  le_r, re_r;
  logic              aq_sat_r;
  logic [TILT_W-1:0] la_abs, ra_abs;

  assign la_abs = abs_ang(la);
  assign ra_abs = abs_ang(ra);

  always_ff @(posedge clk) begin
    if (en) begin
      ta_abs_r <= abs_ang(ta);
      ba_abs_r <= abs_ang(ba);
      la_abs_r <= la_abs;
      ra_abs_r <= ra_abs;
      le_r     <= rect_err(la, roll);
      re_r     <= rect_err(ra, roll);
      aq_sat_r <= (TILT_W'(la_abs >> ANG_SH) >= ra_abs);
    end
  end

  ang_side_t side_r, side_d;
  logic [ANG_DEN_W-1:0] ang_hi_r, ang_den_r;
  logic [ANG_Q_W-1:0]   ang_lo_r, ang_q, ang_q_d;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r.aq_sat <= aq_sat_r;
      side_r.top    <= ta_abs_r;
      side_r.bot    <= ba_abs_r;
      side_r.tdiff  <= (ta_abs_r > ba_abs_r) ? ta_abs_r - ba_abs_r : ba_abs_r - ta_abs_r;
      side_r.rerr   <= (le_r > re_r) ? le_r : re_r;
      side_r.rdiff  <= (le_r > re_r) ? le_r - re_r : re_r - le_r;
      ang_hi_r      <= aq_sat_r ? '0 : ANG_DEN_W'(la_abs_r >> ANG_SH);
      ang_lo_r      <= {la_abs_r[ANG_SH-1:0], {(ANG_Q_W-ANG_SH){1'b0}}};
      ang_den_r     <= ra_abs_r;
    end
  end

  lpgf_divider #(.DEN_W(ANG_DEN_W), .Q_W(ANG_Q_W)) u_ang_div (
    .clk(clk), .en(en), .num_hi(ang_hi_r), .num_lo(ang_lo_r), .den(ang_den_r), .quot(ang_q)
  );
  lpgf_delay #(.W(ANG_Q_W), .DEPTH(ANG_Q_DELAY)) u_angq_dly (
    .clk(clk), .en(en), .d(ang_q), .q(ang_q_d)
  );
  lpgf_delay #(.W($bits(ang_side_t)), .DEPTH(ANG_SIDE_DELAY)) u_side_dly (
    .clk(clk), .en(en), .d(side_r), .q(side_d)
  );

  // result assembly
  always_comb begin
    fin.top_tilt         = side_d.top;
    fin.bottom_tilt      = side_d.bot;
    fin.tilt_difference  = side_d.tdiff;
    fin.angle_quotient   = side_d.aq_sat ? SAT16 : ang_q_d;
    fin.width_ratio      = rsat_d[1] ? SAT16 : wr_root;
    fin.length_ratio     = rsat_d[0] ? SAT16 : sr_root;
    fin.rect_error       = side_d.rerr;
    fin.rect_error_diff  = side_d.rdiff;
    fin.divide_saturated = side_d.aq_sat | rsat_d[1] | rsat_d[0];
  end

  // valid chain, output register and skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-1:1], in_valid};
      if (out_valid_r && !out_ready) begin
        skid_full_r <= vld_r[PIPE_LAT];
      end else begin
        out_valid_r <= vld_r[PIPE_LAT];
      end
    end else if (out_ready) begin
      skid_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (out_valid_r && !out_ready) begin
        skid_word_r <= fin;
      end else begin
        out_word_r <= fin;
      end
    end else if (out_ready) begin
      out_word_r <= skid_word_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

  logic skid_load, tilt_ok;

  assign skid_load = out_valid_r && !out_ready && !skid_full_r && vld_r[PIPE_LAT];
  assign tilt_ok = (out_word_r.top_tilt <= TILT_W'(PI_Q13))
                && (out_word_r.bottom_tilt <= TILT_W'(PI_Q13))
                && (out_word_r.tilt_difference <= TILT_W'(PI_Q13));

  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_full_r, out_valid_r)
  `ASSERT_NEXT(a_skid_catches, clk, rst_n, skid_load, skid_full_r)
  `ASSERT_IMPLIES(a_tilt_range, clk, rst_n, out_valid_r, tilt_ok)

endmodule
